>>> hdl/vac_pkg.sv
`timescale 1ns / 1ps
// shared types, constants and register codes for the velocity/acceleration limiter
// no dependencies
package vac_pkg;

    localparam int VAC_RING_DEPTH = 5;
    localparam int VAC_VEL_WIDTH  = 16;

    localparam int TIME_W     = 32;
    localparam int LIM_W      = 15;
    localparam int FAC_W      = 16;
    localparam int FAC_FRAC   = 8;
    localparam int STEP_W     = LIM_W + FAC_W - FAC_FRAC;
    localparam int MODE_W     = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam int INACT_FW  = 11;
    localparam int RESYNC_FW = 13;
    localparam int INACT_W   = TIME_W + INACT_FW;
    localparam int RESYNC_W  = TIME_W + RESYNC_FW;

    localparam logic [INACT_FW-1:0]  INACT_FACTOR  = INACT_FW'(2000);
    localparam logic [RESYNC_FW-1:0] RESYNC_FACTOR = RESYNC_FW'(5000);
    localparam logic [TIME_W-1:0]    AVG_RESET     = TIME_W'(100000);

    localparam logic [LIM_W-1:0]  SPEED_LIN_RST = LIM_W'(800);
    localparam logic [LIM_W-1:0]  SPEED_ANG_RST = LIM_W'(5400);
    localparam logic [LIM_W-1:0]  ACC_LIN_RST   = LIM_W'(15);
    localparam logic [LIM_W-1:0]  ACC_ANG_RST   = LIM_W'(175);
    localparam logic [FAC_W-1:0]  DEC_FAC_RST   = FAC_W'(256);
    localparam logic [TIME_W-1:0] IDLE_CAP_RST  = TIME_W'(1500000);

    localparam logic [MODE_W-1:0] MODE_NONE  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_ODOM  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CMDFB = 2'd2;
    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

    typedef enum logic [1:0] {
        REQ_CMD   = 2'd0,
        REQ_ODOM  = 2'd1,
        REQ_CMDFB = 2'd2,
        REQ_TICK  = 2'd3
    } t_req;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SPEED_LIN = 3'd0,
        CFG_SPEED_ANG = 3'd1,
        CFG_ACC_LIN   = 3'd2,
        CFG_ACC_ANG   = 3'd3,
        CFG_DEC_FAC   = 3'd4,
        CFG_FB_MODE   = 3'd5,
        CFG_IDLE_CAP  = 3'd6
    } t_cfg_idx;

    typedef struct packed {
        logic load;
        logic cmd_upd;
        logic med_step;
        logic fb_upd;
        logic t_mul;
        logic t_idle;
        logic t_sync;
        logic t_cmp;
        logic t_prod;
        logic div_start;
        logic div_step;
        logic t_apply;
        logic out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic same;
        logic active;
        logic med_done;
        logic div_needed;
        logic div_done;
        logic out_free;
    } t_dp_stat;

endpackage

>>> hdl/vac_if.sv
`timescale 1ns / 1ps
// request and result channel interfaces, valid/ready handshake
// depends on vac_pkg
interface vac_in_if import vac_pkg::*; #(
    parameter int VEL_WIDTH = VAC_VEL_WIDTH
);
    logic                        valid;
    logic                        ready;
    logic [1:0]                  req_type;
    logic [TIME_W-1:0]           now_us;
    logic signed [VEL_WIDTH-1:0] lin_vel;
    logic signed [VEL_WIDTH-1:0] ang_vel;

    modport source (output valid, req_type, now_us, lin_vel, ang_vel, input ready);
    modport sink (input valid, req_type, now_us, lin_vel, ang_vel, output ready);
endinterface

interface vac_out_if import vac_pkg::*; #(
    parameter int VEL_WIDTH = VAC_VEL_WIDTH
);
    logic                        valid;
    logic                        ready;
    logic signed [VEL_WIDTH-1:0] out_lin;
    logic signed [VEL_WIDTH-1:0] out_ang;

    modport source (output valid, out_lin, out_ang, input ready);
    modport sink (input valid, out_lin, out_ang, output ready);
endinterface

>>> hdl/vac_ctrl.sv
`timescale 1ns / 1ps
// sequencing state machine for the limiter: issues datapath commands per transaction
// depends on vac_pkg
module vac_ctrl import vac_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic [1:0] i_req_type,
    output logic       o_in_ready,
    input  t_dp_stat   i_stat,
    output t_dp_cmd    o_cmd
);

    typedef enum logic [12:0] {
        S_IDLE   = 13'b0000000000001,
        S_CMD    = 13'b0000000000010,
        S_MED    = 13'b0000000000100,
        S_FB     = 13'b0000000001000,
        S_TMUL   = 13'b0000000010000,
        S_TIDLE  = 13'b0000000100000,
        S_TSYNC  = 13'b0000001000000,
        S_TCMP   = 13'b0000010000000,
        S_TPROD  = 13'b0000100000000,
        S_TSEL   = 13'b0001000000000,
        S_TDIV   = 13'b0010000000000,
        S_TAPPLY = 13'b0100000000000,
        S_EMIT   = 13'b1000000000000
    } t_state;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    unique case (t_req'(i_req_type))
                        REQ_CMD:   n_state = S_CMD;
                        REQ_ODOM:  n_state = S_FB;
                        REQ_CMDFB: n_state = S_FB;
                        REQ_TICK:  n_state = S_TMUL;
                        default:   n_state = S_IDLE;
                    endcase
                end
            end
            S_CMD: begin
                o_cmd.cmd_upd = 1'b1;
                n_state = S_MED;
            end
            S_MED: begin
                o_cmd.med_step = 1'b1;
                if (i_stat.med_done) begin
                    n_state = S_IDLE;
                end
            end
            S_FB: begin
                o_cmd.fb_upd = 1'b1;
                n_state = S_IDLE;
            end
            S_TMUL: begin
                o_cmd.t_mul = 1'b1;
                n_state = S_TIDLE;
            end
            S_TIDLE: begin
                o_cmd.t_idle = 1'b1;
                n_state = S_TSYNC;
            end
            S_TSYNC: begin
                o_cmd.t_sync = 1'b1;
                n_state = S_TCMP;
            end
            S_TCMP: begin
                if (i_stat.same) begin
                    n_state = i_stat.active ? S_EMIT : S_IDLE;
                end else begin
                    o_cmd.t_cmp = 1'b1;
                    n_state = S_TPROD;
                end
            end
            S_TPROD: begin
                o_cmd.t_prod = 1'b1;
                n_state = S_TSEL;
            end
            S_TSEL: begin
                o_cmd.div_start = 1'b1;
                n_state = i_stat.div_needed ? S_TDIV : S_TAPPLY;
            end
            S_TDIV: begin
                o_cmd.div_step = 1'b1;
                if (i_stat.div_done) begin
                    n_state = S_TAPPLY;
                end
            end
            S_TAPPLY: begin
                o_cmd.t_apply = 1'b1;
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    a_tick_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && i_req_type == REQ_TICK) |=> r_state == S_TMUL)
        else $error("tick transaction did not start the tick sequence");

    a_emit_from_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT) |-> ($past(r_state) == S_TCMP || $past(r_state) == S_TAPPLY
            || $past(r_state) == S_EMIT))
        else $error("result emitted outside the tick sequence");

endmodule

>>> hdl/vac_datapath.sv
`timescale 1ns / 1ps
// limiter datapath: config registers, state, period ring median, step limiting, divider
// depends on vac_pkg; driven by vac_ctrl
module vac_datapath import vac_pkg::*; #(
    parameter int RING_DEPTH = VAC_RING_DEPTH,
    parameter int VEL_WIDTH  = VAC_VEL_WIDTH
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [CFG_IDX_W-1:0]        i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]       i_cfg_data,
    input  logic [1:0]                  i_req_type,
    input  logic [TIME_W-1:0]           i_now_us,
    input  logic signed [VEL_WIDTH-1:0] i_lin_vel,
    input  logic signed [VEL_WIDTH-1:0] i_ang_vel,
    input  t_dp_cmd                     i_cmd,
    output t_dp_stat                    o_stat,
    input  logic                        i_out_ready,
    output logic                        o_out_valid,
    output logic signed [VEL_WIDTH-1:0] o_out_lin,
    output logic signed [VEL_WIDTH-1:0] o_out_ang
);

    localparam int CNT_W  = $clog2(RING_DEPTH + 1);
    localparam int IDX_W  = $clog2(RING_DEPTH);
    localparam int HALF   = RING_DEPTH / 2;
    localparam int MAG_W  = VEL_WIDTH;
    localparam int INC_W  = VEL_WIDTH + 1;
    localparam int PROD_W = STEP_W + MAG_W;
    localparam int CMP_W  = VEL_WIDTH + STEP_W + 2;
    localparam int CL_W   = VEL_WIDTH + LIM_W + 1;
    localparam int DCNT_W = $clog2(PROD_W);
    localparam int DP_W   = LIM_W + FAC_W;

    // configuration
    logic [LIM_W-1:0]  r_spd_lin, r_spd_ang, r_acc_lin, r_acc_ang;
    logic [FAC_W-1:0]  r_dec_fac;
    logic [MODE_W-1:0] r_fb_mode;
    logic [TIME_W-1:0] r_idle_cap;

    // latched transaction
    logic [1:0]                  r_req;
    logic [TIME_W-1:0]           r_now;
    logic signed [VEL_WIDTH-1:0] r_lin, r_ang;

    // block state
    logic signed [VEL_WIDTH-1:0] r_tgt_lin, r_tgt_ang, r_last_lin, r_last_ang;
    logic signed [VEL_WIDTH-1:0] r_meas_lin, r_meas_ang;
    logic                        r_active;
    logic [TIME_W-1:0]           r_last_time;
    logic [TIME_W-1:0]           r_ring [RING_DEPTH];
    logic [CNT_W-1:0]            r_ring_cnt;
    logic [IDX_W-1:0]            r_ring_next;
    logic [TIME_W-1:0]           r_avg;
    logic [IDX_W-1:0]            r_scan;

    // tick working registers
    logic [TIME_W-1:0]   r_elapsed;
    logic [INACT_W-1:0]  r_inact;
    logic [RESYNC_W-1:0] r_resync;
    logic [STEP_W-1:0]   r_dec_lin, r_dec_ang, r_mx_lin, r_mx_ang;
    logic [MAG_W-1:0]    r_al, r_aa;
    logic                r_neg_lin, r_neg_ang;
    logic [PROD_W-1:0]   r_p1, r_p2, r_dq;
    logic [MAG_W-1:0]    r_rem, r_den;
    logic [DCNT_W-1:0]   r_div_cnt;
    logic                r_div_to_lin;

    logic                        r_out_valid;
    logic signed [VEL_WIDTH-1:0] r_out_lin, r_out_ang;

    logic fb_none, odom;
    logic [TIME_W-1:0] elapsed_c;
    logic signed [CL_W-1:0] lin_e, ang_e, slim_e, alim_e, clin, cang;
    logic [CNT_W-1:0]  n_ring_cnt;
    logic [IDX_W-1:0]  n_ring_next;
    logic [TIME_W-1:0] cand;
    logic [CNT_W-1:0]  less_cnt, eq_cnt, med_k;
    logic              med_small, med_match;
    logic [INACT_W-1:0] idle_lim;
    logic [DP_W-1:0]   dec_prod_l, dec_prod_a;
    logic signed [CMP_W-1:0] meas_l_e, meas_a_e, last_l_e, last_a_e;
    logic signed [CMP_W-1:0] dec_l_e, dec_a_e, acc_l_e, acc_a_e;
    logic dev_l, dev_a, idle_hit, resync_hit;
    logic signed [INC_W-1:0] inc_l, inc_a;
    logic [STEP_W-1:0] pick_l, pick_a;
    logic p_sel;
    logic [MAG_W:0]    rem_sh;
    logic              div_ge;
    logic [MAG_W-1:0]  n_rem;
    logic [PROD_W-1:0] n_dq;
    logic [STEP_W-1:0] div_q;
    logic signed [CMP_W-1:0] mxl_e, mxa_e, nl_e, na_e;
    logic signed [VEL_WIDTH-1:0] n_lin, n_ang;

    always_comb begin
        fb_none   = (r_fb_mode == MODE_NONE) || (r_fb_mode == MODE_UNUSED);
        odom      = (r_fb_mode == MODE_ODOM);
        elapsed_c = r_now - r_last_time;

        // command clamp
        lin_e  = {{(CL_W-VEL_WIDTH){r_lin[VEL_WIDTH-1]}}, r_lin};
        ang_e  = {{(CL_W-VEL_WIDTH){r_ang[VEL_WIDTH-1]}}, r_ang};
        slim_e = {{(CL_W-LIM_W){1'b0}}, r_spd_lin};
        alim_e = {{(CL_W-LIM_W){1'b0}}, r_spd_ang};
        if (lin_e > 0) begin
            clin = (lin_e < slim_e) ? lin_e : slim_e;
        end else begin
            clin = (lin_e > -slim_e) ? lin_e : -slim_e;
        end
        if (ang_e > 0) begin
            cang = (ang_e < alim_e) ? ang_e : alim_e;
        end else begin
            cang = (ang_e > -alim_e) ? ang_e : -alim_e;
        end

        n_ring_next = (r_ring_next == IDX_W'(RING_DEPTH - 1)) ? '0 : r_ring_next + 1'b1;
        n_ring_cnt  = (r_ring_cnt == CNT_W'(RING_DEPTH)) ? r_ring_cnt : r_ring_cnt + 1'b1;

        // median: candidate r_scan is the median if it covers sorted index count/2
        cand     = r_ring[r_scan];
        less_cnt = '0;
        eq_cnt   = '0;
        for (int j = 0; j < RING_DEPTH; j++) begin
            if (CNT_W'(j) < r_ring_cnt) begin
                if (r_ring[j] < cand) less_cnt = less_cnt + 1'b1;
                if (r_ring[j] == cand) eq_cnt = eq_cnt + 1'b1;
            end
        end
        med_k     = r_ring_cnt >> 1;
        med_small = (r_ring_cnt <= CNT_W'(HALF));
        med_match = (less_cnt <= med_k) &&
                    ({1'b0, med_k} < ({1'b0, less_cnt} + {1'b0, eq_cnt}));

        // deceleration steps, full-width product
        dec_prod_l = DP_W'(r_dec_fac) * DP_W'(r_acc_lin);
        dec_prod_a = DP_W'(r_dec_fac) * DP_W'(r_acc_ang);

        // inactivity and resync
        idle_lim = (r_inact > INACT_W'(r_idle_cap)) ? INACT_W'(r_idle_cap) : r_inact;
        idle_hit = r_active && (r_avg != '0) && (INACT_W'(r_elapsed) > idle_lim);

        meas_l_e = CMP_W'(r_meas_lin);
        meas_a_e = CMP_W'(r_meas_ang);
        last_l_e = CMP_W'(r_last_lin);
        last_a_e = CMP_W'(r_last_ang);
        dec_l_e  = $signed({{(CMP_W-STEP_W){1'b0}}, r_dec_lin});
        dec_a_e  = $signed({{(CMP_W-STEP_W){1'b0}}, r_dec_ang});
        acc_l_e  = $signed({{(CMP_W-LIM_W){1'b0}}, r_acc_lin});
        acc_a_e  = $signed({{(CMP_W-LIM_W){1'b0}}, r_acc_ang});
        dev_l = (meas_l_e < last_l_e - (dec_l_e <<< 1)) ||
                (meas_l_e > last_l_e + (acc_l_e <<< 1));
        dev_a = (meas_a_e < last_a_e - (dec_a_e <<< 1)) ||
                (meas_a_e > last_a_e + (acc_a_e <<< 1));
        resync_hit = !fb_none && r_active && (r_avg != '0) &&
                     ((RESYNC_W'(r_elapsed) > r_resync) || dev_l || dev_a);

        // step selection
        inc_l = INC_W'(r_tgt_lin) - INC_W'(r_last_lin);
        inc_a = INC_W'(r_tgt_ang) - INC_W'(r_last_ang);
        if (odom && r_meas_lin != '0 && r_tgt_lin != '0 &&
            (r_meas_lin[VEL_WIDTH-1] != r_tgt_lin[VEL_WIDTH-1])) begin
            pick_l = r_dec_lin;
        end else if (inc_l != '0 && r_tgt_lin != '0 &&
                     (inc_l[INC_W-1] == r_tgt_lin[VEL_WIDTH-1])) begin
            pick_l = STEP_W'(r_acc_lin);
        end else begin
            pick_l = r_dec_lin;
        end
        if (odom && r_meas_ang != '0 && r_tgt_ang != '0 &&
            (r_meas_ang[VEL_WIDTH-1] != r_tgt_ang[VEL_WIDTH-1])) begin
            pick_a = r_dec_ang;
        end else if (inc_a != '0 && r_tgt_ang != '0 &&
                     (inc_a[INC_W-1] == r_tgt_ang[VEL_WIDTH-1])) begin
            pick_a = STEP_W'(r_acc_ang);
        end else begin
            pick_a = r_dec_ang;
        end

        // direction-preserving scale, restoring divider
        p_sel  = (r_p1 < r_p2);
        rem_sh = {r_rem, r_dq[PROD_W-1]};
        div_ge = (rem_sh >= {1'b0, r_den});
        n_rem  = div_ge ? MAG_W'(rem_sh - {1'b0, r_den}) : rem_sh[MAG_W-1:0];
        n_dq   = {r_dq[PROD_W-2:0], div_ge};
        div_q  = n_dq[STEP_W-1:0];

        mxl_e = $signed({{(CMP_W-STEP_W){1'b0}}, r_mx_lin});
        mxa_e = $signed({{(CMP_W-STEP_W){1'b0}}, r_mx_ang});
        nl_e  = r_neg_lin ? last_l_e - mxl_e : last_l_e + mxl_e;
        na_e  = r_neg_ang ? last_a_e - mxa_e : last_a_e + mxa_e;
        n_lin = (PROD_W'(r_al) > PROD_W'(r_mx_lin)) ? nl_e[VEL_WIDTH-1:0] : r_tgt_lin;
        n_ang = (PROD_W'(r_aa) > PROD_W'(r_mx_ang)) ? na_e[VEL_WIDTH-1:0] : r_tgt_ang;
    end

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_spd_lin  <= SPEED_LIN_RST;
            r_spd_ang  <= SPEED_ANG_RST;
            r_acc_lin  <= ACC_LIN_RST;
            r_acc_ang  <= ACC_ANG_RST;
            r_dec_fac  <= DEC_FAC_RST;
            r_fb_mode  <= MODE_NONE;
            r_idle_cap <= IDLE_CAP_RST;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_SPEED_LIN: r_spd_lin  <= i_cfg_data[LIM_W-1:0];
                CFG_SPEED_ANG: r_spd_ang  <= i_cfg_data[LIM_W-1:0];
                CFG_ACC_LIN:   r_acc_lin  <= i_cfg_data[LIM_W-1:0];
                CFG_ACC_ANG:   r_acc_ang  <= i_cfg_data[LIM_W-1:0];
                CFG_DEC_FAC:   r_dec_fac  <= i_cfg_data[FAC_W-1:0];
                CFG_FB_MODE:   r_fb_mode  <= i_cfg_data[MODE_W-1:0];
                CFG_IDLE_CAP:  r_idle_cap <= i_cfg_data[TIME_W-1:0];
                default: ;
            endcase
        end
    end

    // period ring, no reset
    always_ff @(posedge i_clk) begin
        if (i_cmd.cmd_upd) begin
            r_ring[r_ring_next] <= elapsed_c;
        end
    end

    // payload and working registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req <= i_req_type;
            r_now <= i_now_us;
            r_lin <= i_lin_vel;
            r_ang <= i_ang_vel;
        end
        if (i_cmd.t_mul) begin
            r_elapsed <= elapsed_c;
            r_inact   <= INACT_W'(r_avg) * INACT_W'(INACT_FACTOR);
            r_resync  <= RESYNC_W'(r_avg) * RESYNC_W'(RESYNC_FACTOR);
            r_dec_lin <= dec_prod_l[DP_W-1:FAC_FRAC];
            r_dec_ang <= dec_prod_a[DP_W-1:FAC_FRAC];
        end
        if (i_cmd.t_cmp) begin
            r_neg_lin <= inc_l[INC_W-1];
            r_neg_ang <= inc_a[INC_W-1];
            r_al      <= MAG_W'(inc_l[INC_W-1] ? -inc_l : inc_l);
            r_aa      <= MAG_W'(inc_a[INC_W-1] ? -inc_a : inc_a);
            r_mx_lin  <= pick_l;
            r_mx_ang  <= pick_a;
        end
        if (i_cmd.t_prod) begin
            r_p1 <= PROD_W'(r_mx_ang) * PROD_W'(r_al);
            r_p2 <= PROD_W'(r_aa) * PROD_W'(r_mx_lin);
        end
        if (i_cmd.div_start) begin
            r_dq         <= p_sel ? r_p1 : r_p2;
            r_den        <= p_sel ? r_aa : r_al;
            r_rem        <= '0;
            r_div_cnt    <= '0;
            r_div_to_lin <= p_sel;
        end
        if (i_cmd.div_step) begin
            r_dq      <= n_dq;
            r_rem     <= n_rem;
            r_div_cnt <= r_div_cnt + 1'b1;
            if (r_div_cnt == DCNT_W'(PROD_W - 1)) begin
                if (r_div_to_lin) r_mx_lin <= div_q;
                else r_mx_ang <= div_q;
            end
        end
        if (i_cmd.cmd_upd) begin
            r_scan <= '0;
        end else if (i_cmd.med_step) begin
            r_scan <= r_scan + 1'b1;
        end
        if (i_cmd.out_load) begin
            r_out_lin <= r_last_lin;
            r_out_ang <= r_last_ang;
        end
    end

    // block state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tgt_lin   <= '0;
            r_tgt_ang   <= '0;
            r_last_lin  <= '0;
            r_last_ang  <= '0;
            r_meas_lin  <= '0;
            r_meas_ang  <= '0;
            r_active    <= 1'b0;
            r_last_time <= '0;
            r_ring_cnt  <= '0;
            r_ring_next <= '0;
            r_avg       <= AVG_RESET;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.cmd_upd) begin
                r_ring_next <= n_ring_next;
                r_ring_cnt  <= n_ring_cnt;
                r_last_time <= r_now;
                r_active    <= 1'b1;
                r_tgt_lin   <= clin[VEL_WIDTH-1:0];
                r_tgt_ang   <= cang[VEL_WIDTH-1:0];
            end
            if (i_cmd.med_step) begin
                if (med_small) r_avg <= AVG_RESET;
                else if (med_match) r_avg <= cand;
            end
            if (i_cmd.fb_upd && !fb_none && r_req == r_fb_mode) begin
                r_meas_lin <= r_lin;
                r_meas_ang <= r_ang;
            end
            if (i_cmd.t_idle && idle_hit) begin
                r_active  <= 1'b0;
                r_tgt_lin <= '0;
                r_tgt_ang <= '0;
            end
            if (i_cmd.t_sync && resync_hit) begin
                r_last_lin <= r_meas_lin;
                r_last_ang <= r_meas_ang;
            end
            if (i_cmd.t_apply) begin
                r_last_lin <= n_lin;
                r_last_ang <= n_ang;
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_comb begin
        o_stat.same       = (r_tgt_lin == r_last_lin) && (r_tgt_ang == r_last_ang);
        o_stat.active     = r_active;
        o_stat.med_done   = med_small || med_match ||
                            ((CNT_W'(r_scan) + 1'b1) >= r_ring_cnt);
        o_stat.div_needed = p_sel ? (r_aa != '0) : (r_al != '0);
        o_stat.div_done   = (r_div_cnt == DCNT_W'(PROD_W - 1));
        o_stat.out_free   = !r_out_valid || i_out_ready;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_lin   = r_out_lin;
    assign o_out_ang   = r_out_ang;

    a_ring_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ring_cnt <= CNT_W'(RING_DEPTH))
        else $error("ring count beyond depth");

    a_div_den: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.div_step |-> r_den != '0)
        else $error("divider running with zero divisor");

    a_scan_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.med_step && !med_small) |-> CNT_W'(r_scan) < r_ring_cnt)
        else $error("median scan past stored entries");

endmodule

>>> hdl/velocity_accel_limiter_core.sv
`timescale 1ns / 1ps
// top level of the velocity/acceleration limiter: controller plus datapath
// depends on vac_pkg, vac_if, vac_ctrl, vac_datapath
//
//  channel  | dir | handshake          | payload
//  i_in     | in  | valid/ready        | req_type, now_us, lin_vel, ang_vel
//  o_out    | out | valid/ready        | out_lin, out_ang
//  i_cfg_*  | in  | write enable only  | register index, 32-bit data
//
// one transaction at a time; ready is high only while the controller is idle
// command: a ring update followed by the median scan of the stored periods
// feedback: an update state; tick: step states plus the shared divider when scaling
// a result waits in the output register; the next transaction is taken meanwhile,
// a tick that needs to emit stalls only until that register is free
// synchronous active-low reset; ring entries are not cleared, only the fill count
module velocity_accel_limiter_core import vac_pkg::*; #(
    parameter int RING_DEPTH = VAC_RING_DEPTH,
    parameter int VEL_WIDTH  = VAC_VEL_WIDTH
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    vac_in_if.sink                i_in,
    vac_out_if.source             o_out
);

    t_dp_cmd  cmd;
    t_dp_stat stat;

    vac_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_req_type (i_in.req_type),
        .o_in_ready (i_in.ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    vac_datapath #(
        .RING_DEPTH (RING_DEPTH),
        .VEL_WIDTH  (VEL_WIDTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_req_type  (i_in.req_type),
        .i_now_us    (i_in.now_us),
        .i_lin_vel   (i_in.lin_vel),
        .i_ang_vel   (i_in.ang_vel),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_out_ready (o_out.ready),
        .o_out_valid (o_out.valid),
        .o_out_lin   (o_out.out_lin),
        .o_out_ang   (o_out.out_ang)
    );

endmodule

>>> dv/tb_velocity_accel_limiter_core.sv
`timescale 1ns / 1ps
// self-checking testbench for velocity_accel_limiter_core: random and directed requests,
// in-bench velocity smoothing predictor, scoreboard on the result channel
// depends on vac_pkg, vac_if and the core rtl
module tb_velocity_accel_limiter_core;
    import vac_pkg::*;

    typedef struct {
        t_req              rq;
        logic [31:0]       now;
        logic signed [15:0] lv;
        logic signed [15:0] av;
    } req_item_t;

    typedef struct {
        logic signed [15:0] lin;
        logic signed [15:0] ang;
    } vel_pair_t;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    vac_in_if  #(.VEL_WIDTH(VAC_VEL_WIDTH)) i_in ();
    vac_out_if #(.VEL_WIDTH(VAC_VEL_WIDTH)) o_out ();

    velocity_accel_limiter_core dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (i_in),
        .o_out      (o_out)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // predictor configuration and state
    longint          spd_lin, spd_ang, acc_lin, acc_ang, dec_fac, fb_mode;
    longint unsigned idle_cap;
    longint          tgt_lin, tgt_ang, prev_lin, prev_ang, fb_lin, fb_ang;
    bit              cmd_active;
    logic [31:0]     last_cmd_t;
    logic [31:0]     period_hist [VAC_RING_DEPTH];
    int              hist_cnt, hist_next;
    longint unsigned avg_per;

    req_item_t req_q[$];
    vel_pair_t vel_q[$];
    int        n_err = 0;
    bit        in_took = 1'b0;
    int        in_quiet = 0, out_quiet = 0;
    int        stall_cyc = 0;
    logic [31:0] cur_t;
    int        n_pushed = 0;
    int unsigned per_us;

    task automatic report_mismatch(string msg);
        $display("mismatch %s at %0t", msg, $realtime);
        n_err++;
    endtask

    function automatic longint clamp_vel(longint v, longint lim);
        if (v > 0) return (v < lim) ? v : lim;
        return (v > -lim) ? v : -lim;
    endfunction

    function automatic longint abs_l(longint v);
        return (v < 0) ? -v : v;
    endfunction

    function automatic longint step_limit(longint inc, longint tgt, longint meas,
                                          longint acc, longint dec);
        if (fb_mode == longint'(MODE_ODOM) && meas * tgt < 0) return dec;
        return (inc * tgt > 0) ? acc : dec;
    endfunction

    function automatic longint unsigned period_median();
        logic [31:0] s [VAC_RING_DEPTH];
        logic [31:0] x;
        int j;
        for (int i = 0; i < hist_cnt; i++) begin
            x = period_hist[i];
            j = i;
            while (j > 0 && s[j-1] > x) begin
                s[j] = s[j-1];
                j--;
            end
            s[j] = x;
        end
        return 64'(s[hist_cnt/2]);
    endfunction

    function automatic void cfg_model(t_cfg_idx idx, logic [31:0] d);
        case (idx)
            CFG_SPEED_LIN: spd_lin = longint'(d[14:0]);
            CFG_SPEED_ANG: spd_ang = longint'(d[14:0]);
            CFG_ACC_LIN:   acc_lin = longint'(d[14:0]);
            CFG_ACC_ANG:   acc_ang = longint'(d[14:0]);
            CFG_DEC_FAC:   dec_fac = longint'(d[15:0]);
            CFG_FB_MODE:   fb_mode = longint'(d[1:0]);
            CFG_IDLE_CAP:  idle_cap = 64'(d);
            default: ;
        endcase
    endfunction

    function automatic void smooth_step(req_item_t it);
        logic [31:0]     elapsed;
        longint          mode, dec_l, dec_a, inc_l, inc_a, al, aa, mx_l, mx_a, nl, na;
        longint unsigned idle_lim;
        bit              dev_l, dev_a;
        vel_pair_t       r;
        elapsed = it.now - last_cmd_t;
        mode = (fb_mode == longint'(MODE_UNUSED)) ? 0 : fb_mode;
        if (it.rq == REQ_CMD) begin
            period_hist[hist_next] = elapsed;
            hist_next = (hist_next + 1) % VAC_RING_DEPTH;
            if (hist_cnt < VAC_RING_DEPTH) hist_cnt++;
            last_cmd_t = it.now;
            avg_per = (hist_cnt <= VAC_RING_DEPTH/2) ? 64'd100000 : period_median();
            cmd_active = 1'b1;
            tgt_lin = clamp_vel(longint'(it.lv), spd_lin);
            tgt_ang = clamp_vel(longint'(it.av), spd_ang);
            return;
        end
        if (it.rq != REQ_TICK) begin
            if (mode != 0 && longint'(it.rq) == mode) begin
                fb_lin = longint'(it.lv);
                fb_ang = longint'(it.av);
            end
            return;
        end
        dec_l = (dec_fac * acc_lin) >>> 8;
        dec_a = (dec_fac * acc_ang) >>> 8;
        idle_lim = 64'd2000 * avg_per;
        if (idle_lim > idle_cap) idle_lim = idle_cap;
        if (cmd_active && avg_per > 0 && longint'(elapsed) > idle_lim) begin
            cmd_active = 1'b0;
            tgt_lin = 0;
            tgt_ang = 0;
        end
        dev_l = fb_lin < prev_lin - 2*dec_l || fb_lin > prev_lin + 2*acc_lin;
        dev_a = fb_ang < prev_ang - 2*dec_a || fb_ang > prev_ang + 2*acc_ang;
        if (mode != 0 && cmd_active && avg_per > 0 &&
            (longint'(elapsed) > 64'd5000 * avg_per || dev_l || dev_a)) begin
            prev_lin = fb_lin;
            prev_ang = fb_ang;
        end
        if (tgt_lin != prev_lin || tgt_ang != prev_ang) begin
            inc_l = tgt_lin - prev_lin;
            inc_a = tgt_ang - prev_ang;
            al = abs_l(inc_l);
            aa = abs_l(inc_a);
            mx_l = step_limit(inc_l, tgt_lin, fb_lin, acc_lin, dec_l);
            mx_a = step_limit(inc_a, tgt_ang, fb_ang, acc_ang, dec_a);
            nl = tgt_lin;
            na = tgt_ang;
            if (mx_a * al < aa * mx_l) begin
                if (aa != 0) mx_l = (mx_a * al) / aa;
            end else begin
                if (al != 0) mx_a = (mx_l * aa) / al;
            end
            if (al > mx_l) nl = prev_lin + ((inc_l < 0) ? -mx_l : mx_l);
            if (aa > mx_a) na = prev_ang + ((inc_a < 0) ? -mx_a : mx_a);
            prev_lin = nl;
            prev_ang = na;
        end else if (!cmd_active) begin
            return;
        end
        r.lin = prev_lin[15:0];
        r.ang = prev_ang[15:0];
        vel_q = {vel_q, r};
    endfunction

    function automatic bit take_gap(inout int quiet);
        if (quiet > 0) begin
            quiet--;
            return 1'b0;
        end
        if ($urandom_range(999) == 0) quiet = 400;
        return $urandom_range(99) < 14;
    endfunction

    // monitor and scoreboard
    always @(posedge i_clk) begin
        vel_pair_t w;
        req_item_t it;
        in_took = 1'b0;
        if (i_rst_n) begin
            stall_cyc++;
            if (o_out.valid && o_out.ready) begin
                stall_cyc = 0;
                if (vel_q.size() == 0) begin
                    report_mismatch($sformatf("unexpected result lin %0d ang %0d",
                                              o_out.out_lin, o_out.out_ang));
                end else begin
                    w = vel_q.pop_front();
                    if (o_out.out_lin !== w.lin)
                        report_mismatch($sformatf("out_lin: got %0d expected %0d",
                                                  o_out.out_lin, w.lin));
                    if (o_out.out_ang !== w.ang)
                        report_mismatch($sformatf("out_ang: got %0d expected %0d",
                                                  o_out.out_ang, w.ang));
                end
            end
            if (i_in.valid && i_in.ready) begin
                stall_cyc = 0;
                in_took = 1'b1;
                it.rq = t_req'(i_in.req_type);
                it.now = i_in.now_us;
                it.lv = i_in.lin_vel;
                it.av = i_in.ang_vel;
                smooth_step(it);
                void'(req_q.pop_front());
            end
            if (i_cfg_we) stall_cyc = 0;
            if (stall_cyc > 20000) begin
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    // request driver
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_in.valid <= 1'b0;
        end else if (!(i_in.valid && !in_took)) begin
            if (req_q.size() > 0 && !take_gap(in_quiet)) begin
                i_in.valid    <= 1'b1;
                i_in.req_type <= req_q[0].rq;
                i_in.now_us   <= req_q[0].now;
                i_in.lin_vel  <= req_q[0].lv;
                i_in.ang_vel  <= req_q[0].av;
            end else begin
                i_in.valid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin
        if (!i_rst_n) o_out.ready <= 1'b0;
        else o_out.ready <= !take_gap(out_quiet);
    end

    task automatic push_req(t_req rq, logic [31:0] t, logic [15:0] lv, logic [15:0] av);
        req_item_t it;
        it.rq = rq;
        it.now = t;
        it.lv = lv;
        it.av = av;
        req_q = {req_q, it};
        n_pushed++;
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [31:0] v, int w);
        logic [31:0] d;
        d = v;
        if (w < 32 && $urandom_range(1)) d = d | ($urandom << w);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= d;
        cfg_model(idx, d);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic set_all(logic [14:0] sl, logic [14:0] sa, logic [14:0] al, logic [14:0] aa,
                           logic [15:0] df, logic [1:0] md, logic [31:0] cap);
        write_reg(CFG_SPEED_LIN, 32'(sl), 15);
        write_reg(CFG_SPEED_ANG, 32'(sa), 15);
        write_reg(CFG_ACC_LIN, 32'(al), 15);
        write_reg(CFG_ACC_ANG, 32'(aa), 15);
        write_reg(CFG_DEC_FAC, 32'(df), 16);
        write_reg(CFG_FB_MODE, 32'(md), 2);
        write_reg(CFG_IDLE_CAP, cap, 32);
    endtask

    task automatic drain();
        wait (req_q.size() == 0);
        wait (vel_q.size() == 0);
        repeat (80) @(posedge i_clk);
    endtask

    function automatic logic [15:0] rand_vel();
        case ($urandom_range(3))
            0: return 16'($urandom);
            1: return 16'($signed($urandom_range(8000)) - 4000);
            default: return 16'($signed($urandom_range(1600)) - 800);
        endcase
    endfunction

    function automatic logic [31:0] rand_dt();
        case ($urandom_range(19))
            0: return $urandom;
            1: return 32'd0;
            2: return per_us * 6000 + $urandom_range(1000);
            3, 4: return per_us * 2100;
            default: return $urandom_range(per_us) + 1;
        endcase
    endfunction

    task automatic rand_phase(int n);
        int stop;
        int k;
        stop = n_pushed + n;
        while (n_pushed < stop) begin
            if ($urandom_range(9) == 0) begin
                cur_t += ($urandom_range(1) ? rand_dt() : 32'($urandom));
                push_req(t_req'($urandom_range(3)), cur_t, 16'($urandom), 16'($urandom));
            end else begin
                cur_t += rand_dt();
                push_req(REQ_CMD, cur_t, rand_vel(), rand_vel());
                k = $urandom_range(1, 8);
                for (int i = 0; i < k; i++) begin
                    if ($urandom_range(2) == 0)
                        push_req($urandom_range(1) ? REQ_ODOM : REQ_CMDFB,
                                 cur_t, rand_vel(), rand_vel());
                    cur_t += ($urandom_range(3) == 0) ? rand_dt() : $urandom_range(per_us);
                    push_req(REQ_TICK, cur_t, 16'($urandom), 16'($urandom));
                end
            end
        end
        drain();
    endtask

    initial begin
        i_in.valid = 1'b0;
        i_in.req_type = REQ_TICK;
        i_in.now_us = '0;
        i_in.lin_vel = '0;
        i_in.ang_vel = '0;
        o_out.ready = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = CFG_SPEED_LIN;
        i_cfg_data = '0;
        spd_lin = 800; spd_ang = 5400; acc_lin = 15; acc_ang = 175;
        dec_fac = 256; fb_mode = 0; idle_cap = 1500000;
        tgt_lin = 0; tgt_ang = 0; prev_lin = 0; prev_ang = 0; fb_lin = 0; fb_ang = 0;
        cmd_active = 1'b0; last_cmd_t = '0; hist_cnt = 0; hist_next = 0;
        avg_per = 100000;
        cur_t = '0;
        per_us = 20000;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: extremes, clamping, zero linear change, feedback, wrap and timeouts
        push_req(REQ_TICK, 32'd10, 16'h7FFF, 16'h8000);
        push_req(REQ_CMD, 32'd0, 16'h7FFF, 16'h8000);
        push_req(REQ_TICK, 32'd100, '0, '0);
        push_req(REQ_TICK, 32'd200, '0, '0);
        push_req(REQ_CMD, 32'd20000, 16'h8000, 16'h7FFF);
        push_req(REQ_TICK, 32'd20100, '0, '0);
        push_req(REQ_CMD, 32'd40000, 16'h0000, 16'h0100);
        push_req(REQ_TICK, 32'd40100, '0, '0);
        push_req(REQ_CMD, 32'd60000, 16'h0000, 16'hFF00);
        push_req(REQ_TICK, 32'd60100, '0, '0);
        push_req(REQ_ODOM, 32'd60200, 16'h0100, 16'hFFF0);
        push_req(REQ_CMDFB, 32'd60300, 16'h7FFF, 16'h8000);
        push_req(REQ_CMD, 32'hFFFF_FF00, 16'h0000, 16'h0000);
        push_req(REQ_TICK, 32'h0000_0010, '0, '0);
        push_req(REQ_CMD, 32'h0000_0020, 16'h0010, 16'h0000);
        push_req(REQ_TICK, 32'h0000_0020, '0, '0);
        push_req(REQ_TICK, 32'h0020_0000, '0, '0);
        push_req(REQ_TICK, 32'h0020_0010, '0, '0);
        cur_t = 32'h0030_0000;
        drain();

        set_all(15'd800, 15'd5400, 15'd15, 15'd175, 16'd256, MODE_ODOM, 32'd1500000);
        per_us = 200;
        rand_phase(150);
        set_all(15'h7FFF, 15'h7FFF, 15'h7FFF, 15'h7FFF, 16'hFFFF, MODE_CMDFB, 32'hFFFF_FFFF);
        per_us = 5000;
        rand_phase(120);
        set_all('0, '0, '0, '0, '0, MODE_NONE, '0);
        rand_phase(80);
        set_all(15'd2000, 15'd3000, 15'd40, 15'd90, 16'd512, MODE_UNUSED, 32'd300000);
        per_us = 50;
        rand_phase(120);
        for (int p = 0; p < 5; p++) begin
            per_us = ($urandom_range(1)) ? 100 : 20000;
            set_all(15'($urandom), 15'($urandom_range(6000)),
                    ($urandom_range(3) == 0) ? 15'($urandom) : 15'($urandom_range(1, 400)),
                    ($urandom_range(3) == 0) ? 15'($urandom) : 15'($urandom_range(1, 400)),
                    16'($urandom_range(1023)), 2'($urandom_range(3)),
                    ($urandom_range(1)) ? $urandom : $urandom_range(2000000));
            rand_phase(150);
        end

        if (n_err == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

>>> filelist.f
hdl/vac_pkg.sv
hdl/vac_if.sv
hdl/vac_ctrl.sv
hdl/vac_datapath.sv
hdl/velocity_accel_limiter_core.sv
dv/tb_velocity_accel_limiter_core.sv
